// File: rtl/smx_pkg.sv
`default_nettype none

package smx_pkg;

	// Datapath and field widths
	localparam int DATA_W  = 32;
	localparam int OP_W    = 5;
	localparam int FAULT_W = 3;
	localparam int FLAG_W  = 2;

	// Program space is a power of two, so index wrap is a plain truncation
	localparam int PROGRAM_DEPTH = 1024;
	localparam int IDX_W         = $clog2(PROGRAM_DEPTH);

	// Defaults for the top-level parameters
	localparam int STACK_DEPTH_DEF    = 32;
	localparam int REGISTER_COUNT_DEF = 4;

	// Opcodes
	localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
	localparam logic [OP_W-1:0] OP_PUSHI = 5'd1;
	localparam logic [OP_W-1:0] OP_PUSHR = 5'd2;
	localparam logic [OP_W-1:0] OP_POPR  = 5'd3;
	localparam logic [OP_W-1:0] OP_ADD   = 5'd4;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL   = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV   = 5'd7;
	localparam logic [OP_W-1:0] OP_MOD   = 5'd8;
	localparam logic [OP_W-1:0] OP_OR    = 5'd9;
	localparam logic [OP_W-1:0] OP_XOR   = 5'd10;
	localparam logic [OP_W-1:0] OP_AND   = 5'd11;
	localparam logic [OP_W-1:0] OP_SHL   = 5'd12;
	localparam logic [OP_W-1:0] OP_SHR   = 5'd13;
	localparam logic [OP_W-1:0] OP_NOT   = 5'd14;
	localparam logic [OP_W-1:0] OP_NEG   = 5'd15;
	localparam logic [OP_W-1:0] OP_CMP   = 5'd16;
	localparam logic [OP_W-1:0] OP_BEQ   = 5'd17;
	localparam logic [OP_W-1:0] OP_BNE   = 5'd18;
	localparam logic [OP_W-1:0] OP_BGT   = 5'd19;
	localparam logic [OP_W-1:0] OP_BLT   = 5'd20;
	localparam logic [OP_W-1:0] OP_BGE   = 5'd21;
	localparam logic [OP_W-1:0] OP_BLE   = 5'd22;
	localparam logic [OP_W-1:0] OP_CALL  = 5'd23;
	localparam logic [OP_W-1:0] OP_JMP   = 5'd24;
	localparam logic [OP_W-1:0] OP_RET   = 5'd25;
	localparam logic [OP_W-1:0] OP_END   = 5'd26;

	// Fault codes
	localparam logic [FAULT_W-1:0] FLT_NONE      = 3'd0;
	localparam logic [FAULT_W-1:0] FLT_OVERFLOW  = 3'd1;
	localparam logic [FAULT_W-1:0] FLT_UNDERFLOW = 3'd2;
	localparam logic [FAULT_W-1:0] FLT_DIVZERO   = 3'd3;
	localparam logic [FAULT_W-1:0] FLT_BADREG    = 3'd4;

	// Compare flag codes
	localparam logic [FLAG_W-1:0] FLAG_EQ = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_GT = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_LT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [DATA_W-1:0] argument;
		logic [IDX_W-1:0]         current_index;
	} instr_t;

	typedef struct packed {
		logic [IDX_W-1:0]         next_index;
		logic                     halted;
		logic signed [DATA_W-1:0] register_zero;
		logic [FAULT_W-1:0]       fault;
	} result_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic              want_rem;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] value;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/stack_machine_execute.sv
// Execute stage of a 32-bit stack machine. Each instr request carries one fetched
// instruction (opcode, argument, its program index) and yields exactly one result
// request with the next program index, a halt mark, register 0 after the step and
// a fault code. The block handles one instruction at a time: instr_ready is high
// only while it is idle. Most instructions first read the top two stack entries
// from the registered-read stack memory, then execute and write back. Divide and
// modulo run through a bit-serial restoring divider. A finished result sits in
// an output register, so the next instruction is taken while it waits; if that
// register is still full when the next result is ready, the block holds until it
// drains. A faulting instruction changes no state.
// The operand stack is not cleared at reset; the depth count guards every read.
`default_nettype none

module stack_machine_execute
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    instr_valid,
	output logic         instr_ready,
	input  wire instr_t  instr,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int RIW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_HOLD
	} state_t;

	state_t            state_q;
	instr_t            instr_q;
	logic [DW-1:0]     depth_q;
	logic [FLAG_W-1:0] cmp_q;
	logic [DATA_W-1:0] regs_q [REGISTER_COUNT];
	result_t           out_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] sec_q;

	logic [DW-1:0]     depth_m1;
	logic [DW-1:0]     depth_m2;
	logic [AW-1:0]     top_addr;
	logic [AW-1:0]     sec_addr;
	logic [AW-1:0]     push_addr;

	logic              has1;
	logic              has2;
	logic              full;
	logic              reg_ok;
	logic [RIW-1:0]    reg_idx;

	logic [DATA_W-1:0] alu_result;
	logic [FLAG_W-1:0] alu_flag;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              reg_we;
	logic              cmp_we;
	logic              go_div;
	logic              finish;
	logic              taken;
	logic [DW-1:0]     depth_d;
	logic [IDX_W-1:0]  next_d;
	logic              halted_d;
	logic [FAULT_W-1:0] fault_d;
	logic [DATA_W-1:0] reg0_d;
	result_t           res_d;
	logic              slot_free;
	logic              load_out;

	// Stack pointers derived from the depth count
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign top_addr  = depth_m1[AW-1:0];
	assign sec_addr  = depth_m2[AW-1:0];
	assign push_addr = depth_q[AW-1:0];

	assign has1   = (depth_q != '0);
	assign has2   = (depth_q >= DW'(2));
	assign full   = (depth_q == DW'(STACK_DEPTH));
	assign reg_ok = ($unsigned(instr_q.argument) < DATA_W'(REGISTER_COUNT));
	assign reg_idx = instr_q.argument[RIW-1:0];

	// Operand stack: one write port, two registered read ports at top and second
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		top_q <= stack_mem[top_addr];
		sec_q <= stack_mem[sec_addr];
	end

	smx_alu u_alu (
		.op     (instr_q.opcode),
		.a      (sec_q),
		.b      (top_q),
		.result (alu_result),
		.flag   (alu_flag)
	);

	assign div_req.start    = go_div;
	assign div_req.want_rem = (instr_q.opcode == OP_MOD);
	assign div_req.dividend = sec_q;
	assign div_req.divisor  = top_q;

	smx_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Instruction decode, fault checks and write-back control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = push_addr;
		mem_wdata = alu_result;
		reg_we    = 1'b0;
		cmp_we    = 1'b0;
		go_div    = 1'b0;
		taken     = 1'b0;
		depth_d   = depth_q;
		next_d    = instr_q.current_index + IDX_W'(1);
		halted_d  = 1'b0;
		fault_d   = FLT_NONE;

		if (state_q == S_EXEC) begin
			case (instr_q.opcode) inside
				OP_PUSHI: begin
					if (full) begin
						fault_d = FLT_OVERFLOW;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = instr_q.argument;
						depth_d   = depth_q + DW'(1);
					end
				end
				OP_PUSHR: begin
					if (!reg_ok) begin
						fault_d = FLT_BADREG;
					end else if (full) begin
						fault_d = FLT_OVERFLOW;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = regs_q[reg_idx];
						depth_d   = depth_q + DW'(1);
					end
				end
				OP_POPR: begin
					if (!reg_ok) begin
						fault_d = FLT_BADREG;
					end else if (!has1) begin
						fault_d = FLT_UNDERFLOW;
					end else begin
						reg_we  = 1'b1;
						depth_d = depth_m1;
					end
				end
				[OP_ADD:OP_SHR]: begin
					if (!has2) begin
						fault_d = FLT_UNDERFLOW;
					end else if (instr_q.opcode == OP_DIV || instr_q.opcode == OP_MOD) begin
						if (top_q == '0) begin
							fault_d = FLT_DIVZERO;
						end else begin
							go_div = 1'b1;
						end
					end else begin
						mem_we    = 1'b1;
						mem_waddr = sec_addr;
						depth_d   = depth_m1;
					end
				end
				OP_NOT, OP_NEG: begin
					if (!has1) begin
						fault_d = FLT_UNDERFLOW;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = top_addr;
					end
				end
				OP_CMP: begin
					if (!has2) begin
						fault_d = FLT_UNDERFLOW;
					end else begin
						cmp_we  = 1'b1;
						depth_d = depth_m2;
					end
				end
				OP_BEQ: taken = (cmp_q == FLAG_EQ);
				OP_BNE: taken = (cmp_q != FLAG_EQ);
				OP_BGT: taken = (cmp_q == FLAG_GT);
				OP_BLT: taken = (cmp_q == FLAG_LT);
				OP_BGE: taken = (cmp_q != FLAG_LT);
				OP_BLE: taken = (cmp_q != FLAG_GT);
				OP_CALL: begin
					if (full) begin
						fault_d = FLT_OVERFLOW;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = {{(DATA_W - IDX_W){1'b0}}, instr_q.current_index};
						depth_d   = depth_q + DW'(1);
						taken     = 1'b1;
					end
				end
				OP_JMP: taken = 1'b1;
				OP_RET: begin
					if (!has1) begin
						fault_d = FLT_UNDERFLOW;
					end else begin
						next_d  = top_q[IDX_W-1:0] + IDX_W'(1);
						depth_d = depth_m1;
					end
				end
				OP_END: begin
					halted_d = 1'b1;
					next_d   = instr_q.current_index;
				end
				default: ;
			endcase
		end else if (state_q == S_DIV && div_rsp.done) begin
			// Divider result replaces the second entry
			mem_we    = 1'b1;
			mem_waddr = sec_addr;
			mem_wdata = div_rsp.value;
			depth_d   = depth_m1;
		end

		if (taken) begin
			next_d = instr_q.argument[IDX_W-1:0];
		end
	end

	// Result assembly; register 0 reflects a pop into it on this step
	assign reg0_d = (reg_we && reg_idx == RIW'(0)) ? top_q : regs_q[0];
	assign finish = (state_q == S_EXEC && !go_div) || (state_q == S_DIV && div_rsp.done);
	assign slot_free = !out_valid_q || result_ready;
	assign load_out  = (finish || state_q == S_HOLD) && slot_free;

	always_comb begin
		res_d.next_index    = next_d;
		res_d.halted        = halted_d;
		res_d.register_zero = reg0_d;
		res_d.fault         = fault_d;
	end

	// Sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			instr_q     <= '0;
			depth_q     <= '0;
			cmp_q       <= FLAG_EQ;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				regs_q[i] <= '0;
			end
			out_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Drained and not refilled this cycle
			if (result_valid && result_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end

			if (finish) begin
				depth_q <= depth_d;
			end
			if (cmp_we) begin
				cmp_q <= alu_flag;
			end
			if (reg_we) begin
				regs_q[reg_idx] <= top_q;
			end

			case (state_q)
				S_IDLE: begin
					if (instr_valid) begin
						instr_q <= instr;
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_DIV: begin
					if (finish) begin
						if (slot_free) begin
							out_q       <= res_d;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							res_q   <= res_d;
							state_q <= S_HOLD;
						end
					end else if (go_div) begin
						state_q <= S_DIV;
					end
				end
				S_HOLD: begin
					if (slot_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign instr_ready  = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// File: rtl/smx_alu.sv
`default_nettype none

module smx_alu
	import smx_pkg::*;
(
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [DATA_W-1:0] a,      // second entry
	input  wire logic [DATA_W-1:0] b,      // top entry
	output logic      [DATA_W-1:0] result,
	output logic      [FLAG_W-1:0] flag
);

	logic [4:0] shamt;

	assign shamt = b[4:0];

	// Combinational operations; divide and modulo go to the divider
	always_comb begin
		case (op)
			OP_ADD:  result = a + b;
			OP_SUB:  result = a - b;
			OP_MUL:  result = a * b;
			OP_OR:   result = a | b;
			OP_XOR:  result = a ^ b;
			OP_AND:  result = a & b;
			OP_SHL:  result = a << shamt;
			OP_SHR:  result = DATA_W'($signed(a) >>> shamt);
			OP_NOT:  result = (b == '0) ? DATA_W'(1) : '0;
			OP_NEG:  result = '0 - b;
			default: result = DATA_W'($signed(a) >>> shamt);
		endcase
	end

	// Signed three-way compare, second against top
	always_comb begin
		if (a == b) begin
			flag = FLAG_EQ;
		end else if ($signed(a) > $signed(b)) begin
			flag = FLAG_GT;
		end else begin
			flag = FLAG_LT;
		end
	end

endmodule

`default_nettype wire

// File: rtl/smx_divider.sv
`default_nettype none

module smx_divider
	import smx_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(DATA_W);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIX
	} dstate_t;

	dstate_t           state_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              qneg_q;
	logic              rneg_q;
	logic              want_rem_q;
	logic              done_q;
	logic [DATA_W-1:0] value_q;

	logic [DATA_W-1:0] dvd_mag;
	logic [DATA_W-1:0] dvs_mag;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	// Operand magnitudes; the most negative value maps to its unsigned magnitude
	assign dvd_mag = req.dividend[DATA_W-1] ? '0 - req.dividend : req.dividend;
	assign dvs_mag = req.divisor[DATA_W-1]  ? '0 - req.divisor  : req.divisor;

	// One restoring step: bring in the next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= D_IDLE;
			quo_q      <= '0;
			rem_q      <= '0;
			dvs_q      <= '0;
			cnt_q      <= '0;
			qneg_q     <= 1'b0;
			rneg_q     <= 1'b0;
			want_rem_q <= 1'b0;
			done_q     <= 1'b0;
			value_q    <= '0;
		end else begin
			// Done pulses for one cycle after the sign fix-up
			done_q <= (state_q == D_FIX);
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						quo_q      <= dvd_mag;
						rem_q      <= '0;
						dvs_q      <= dvs_mag;
						cnt_q      <= CNT_W'(DATA_W - 1);
						qneg_q     <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
						rneg_q     <= req.dividend[DATA_W-1];
						want_rem_q <= req.want_rem;
						state_q    <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
					if (cnt_q == '0) begin
						state_q <= D_FIX;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				D_FIX: begin
					// Quotient truncates toward zero, remainder follows the dividend
					if (want_rem_q) begin
						value_q <= rneg_q ? '0 - rem_q : rem_q;
					end else begin
						value_q <= qneg_q ? '0 - quo_q : quo_q;
					end
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

`default_nettype wire

// File: tb/stack_machine_execute_tb.sv
`default_nettype none

module stack_machine_execute_tb;
	import smx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1275;
	localparam int DRAIN_CYCLES = 60;

	// Directed stimulus row; want is used only when typed is set
	typedef struct {
		instr_t  ins;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    instr_valid  = 1'b0;
	logic    instr_ready;
	instr_t  instr        = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Predicted machine state
	logic [DATA_W-1:0] gpr [REGISTER_COUNT_DEF];
	logic [DATA_W-1:0] opstack [STACK_DEPTH_DEF];
	int                depth;
	logic [FLAG_W-1:0] cmp_flag;

	// Stimulus generator state
	logic [IDX_W-1:0] pc;
	int               burst;
	bit               no_idle;
	int               hold_cnt;

	result_t  pending_results [$];
	dir_row_t dir_rows [$];
	int       errors;
	int       cycles;

	stack_machine_execute u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Executes one instruction against the predicted state
	function automatic result_t exec_step(instr_t ins);
		result_t           res;
		logic [DATA_W-1:0] arg, a, b, v;
		longint            sa, sb, q;
		logic              taken;
		arg = ins.argument;
		taken = 1'b0;
		res.next_index = ins.current_index + 1'b1;
		res.halted = 1'b0;
		res.fault = FLT_NONE;
		case (ins.opcode)
			OP_PUSHI: begin
				if (depth >= STACK_DEPTH_DEF) begin
					res.fault = FLT_OVERFLOW;
				end else begin
					opstack[depth] = arg;
					depth++;
				end
			end
			OP_PUSHR: begin
				// register index is checked ahead of the stack
				if (arg >= REGISTER_COUNT_DEF) begin
					res.fault = FLT_BADREG;
				end else if (depth >= STACK_DEPTH_DEF) begin
					res.fault = FLT_OVERFLOW;
				end else begin
					opstack[depth] = gpr[arg];
					depth++;
				end
			end
			OP_POPR: begin
				if (arg >= REGISTER_COUNT_DEF) begin
					res.fault = FLT_BADREG;
				end else if (depth < 1) begin
					res.fault = FLT_UNDERFLOW;
				end else begin
					depth--;
					gpr[arg] = opstack[depth];
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
			OP_OR, OP_XOR, OP_AND, OP_SHL, OP_SHR: begin
				if (depth < 2) begin
					res.fault = FLT_UNDERFLOW;
				end else begin
					// second entry is the left operand
					b = opstack[depth-1];
					a = opstack[depth-2];
					if ((ins.opcode == OP_DIV || ins.opcode == OP_MOD) && b == '0) begin
						res.fault = FLT_DIVZERO;
					end else begin
						sa = $signed(a);
						sb = $signed(b);
						case (ins.opcode)
							OP_ADD: v = a + b;
							OP_SUB: v = a - b;
							OP_MUL: v = a * b;
							OP_DIV: begin
								q = sa / sb;
								v = q[DATA_W-1:0];
							end
							OP_MOD: begin
								q = sa % sb;
								v = q[DATA_W-1:0];
							end
							OP_OR:  v = a | b;
							OP_XOR: v = a ^ b;
							OP_AND: v = a & b;
							OP_SHL: v = a << b[4:0];
							default: v = $signed(a) >>> b[4:0];
						endcase
						opstack[depth-2] = v;
						depth--;
					end
				end
			end
			OP_NOT, OP_NEG: begin
				if (depth < 1) begin
					res.fault = FLT_UNDERFLOW;
				end else begin
					v = opstack[depth-1];
					if (ins.opcode == OP_NOT)
						opstack[depth-1] = (v == '0) ? 32'd1 : 32'd0;
					else
						opstack[depth-1] = 32'd0 - v;
				end
			end
			OP_CMP: begin
				if (depth < 2) begin
					res.fault = FLT_UNDERFLOW;
				end else begin
					a = opstack[depth-2];
					b = opstack[depth-1];
					if (a == b)
						cmp_flag = FLAG_EQ;
					else if ($signed(a) > $signed(b))
						cmp_flag = FLAG_GT;
					else
						cmp_flag = FLAG_LT;
					depth -= 2;
				end
			end
			OP_BEQ: taken = (cmp_flag == FLAG_EQ);
			OP_BNE: taken = (cmp_flag != FLAG_EQ);
			OP_BGT: taken = (cmp_flag == FLAG_GT);
			OP_BLT: taken = (cmp_flag == FLAG_LT);
			OP_BGE: taken = (cmp_flag != FLAG_LT);
			OP_BLE: taken = (cmp_flag != FLAG_GT);
			OP_CALL: begin
				if (depth >= STACK_DEPTH_DEF) begin
					res.fault = FLT_OVERFLOW;
				end else begin
					opstack[depth] = {{(DATA_W-IDX_W){1'b0}}, ins.current_index};
					depth++;
					taken = 1'b1;
				end
			end
			OP_JMP: taken = 1'b1;
			OP_RET: begin
				if (depth < 1) begin
					res.fault = FLT_UNDERFLOW;
				end else begin
					depth--;
					v = opstack[depth];
					res.next_index = v[IDX_W-1:0] + 1'b1;
				end
			end
			OP_END: begin
				res.halted = 1'b1;
				res.next_index = ins.current_index;
			end
			default: ;
		endcase
		if (taken)
			res.next_index = arg[IDX_W-1:0];
		res.register_zero = gpr[0];
		return res;
	endfunction

	function automatic dir_row_t mk_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] arg,
			logic [IDX_W-1:0] idx, bit typed, logic [IDX_W-1:0] nidx, logic halt,
			logic [DATA_W-1:0] r0, logic [FAULT_W-1:0] flt);
		dir_row_t row;
		row.ins.opcode = op;
		row.ins.argument = arg;
		row.ins.current_index = idx;
		row.typed = typed;
		row.want.next_index = nidx;
		row.want.halted = halt;
		row.want.register_zero = r0;
		row.want.fault = flt;
		return row;
	endfunction

	// Immediates lean on the extremes and on small values
	function automatic logic [DATA_W-1:0] rand_imm();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5, 6: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_reg();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, REGISTER_COUNT_DEF - 1);
	endfunction

	// Next random instruction; mostly follows the predicted program flow
	function automatic instr_t gen_instr();
		instr_t x;
		int     r;
		x.argument = rand_imm();
		x.current_index = pc;
		r = $urandom_range(0, 99);
		if (burst == 1) begin
			// fill the stack, then push or call once more
			if (depth < STACK_DEPTH_DEF) begin
				x.opcode = OP_PUSHI;
			end else begin
				x.opcode = $urandom_range(0, 1) ? OP_CALL : OP_PUSHI;
				burst = 2;
			end
		end else if (burst == 2) begin
			// drain it, then issue one more instruction that underflows
			if (depth > 0) begin
				if (r < 40) begin
					x.opcode = OP_POPR;
					x.argument = $urandom_range(0, REGISTER_COUNT_DEF - 1);
				end else if (r < 80) begin
					x.opcode = OP_W'($urandom_range(OP_ADD, OP_SHR));
				end else if (r < 90) begin
					x.opcode = OP_NEG;
				end else begin
					x.opcode = OP_RET;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: x.opcode = OP_POPR;
					1: x.opcode = OP_CMP;
					2: x.opcode = OP_RET;
					default: x.opcode = OP_NOT;
				endcase
				if (x.opcode == OP_POPR)
					x.argument = $urandom_range(0, REGISTER_COUNT_DEF - 1);
				burst = 0;
			end
		end else if (r < 8) begin
			x.opcode = OP_W'($urandom_range(0, 31));
			x.argument = $urandom;
			x.current_index = IDX_W'($urandom);
		end else if ((depth < 2 && r < 60) || r < 28) begin
			if ($urandom_range(0, 9) < 7) begin
				x.opcode = OP_PUSHI;
			end else begin
				x.opcode = OP_PUSHR;
				x.argument = rand_reg();
			end
		end else if (r < 50) begin
			x.opcode = OP_W'($urandom_range(OP_ADD, OP_SHR));
		end else if (r < 58) begin
			x.opcode = $urandom_range(0, 1) ? OP_NOT : OP_NEG;
		end else if (r < 66) begin
			x.opcode = OP_CMP;
		end else if (r < 78) begin
			x.opcode = OP_W'($urandom_range(OP_BEQ, OP_BLE));
			x.argument = $urandom;
		end else if (r < 84) begin
			x.opcode = OP_POPR;
			x.argument = rand_reg();
		end else if (r < 89) begin
			x.opcode = OP_CALL;
			x.argument = $urandom;
		end else if (r < 94) begin
			x.opcode = OP_RET;
		end else if (r < 96) begin
			x.opcode = OP_JMP;
			x.argument = $urandom;
		end else if (r < 98) begin
			x.opcode = OP_NOP;
		end else begin
			x.opcode = OP_END;
		end
		return x;
	endfunction

	// Present one instruction request and hold it until taken
	task automatic send_instr(instr_t x, result_t want);
		int gap;
		gap = no_idle ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr <= x;
		instr_valid <= 1'b1;
		do
			@(posedge clk);
		while (!instr_ready);
		pending_results.push_back(want);
	endtask

	// Result side back-pressure
	always @(negedge clk) begin
		if (hold_cnt == 0 && !no_idle && $urandom_range(0, 3) == 0)
			hold_cnt = gap_len();
		if (hold_cnt > 0) begin
			result_ready <= 1'b0;
			hold_cnt--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Compare each result request with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result next_index %0d halted %0b r0 %h fault %0d",
					$time, result.next_index, result.halted, result.register_zero,
					result.fault);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.next_index !== want.next_index) begin
					$display("%0t: next_index expected %0d got %0d",
						$time, want.next_index, result.next_index);
					errors++;
				end
				if (result.halted !== want.halted) begin
					$display("%0t: halted expected %0b got %0b",
						$time, want.halted, result.halted);
					errors++;
				end
				if (result.register_zero !== want.register_zero) begin
					$display("%0t: register_zero expected %h got %h",
						$time, want.register_zero, result.register_zero);
					errors++;
				end
				if (result.fault !== want.fault) begin
					$display("%0t: fault expected %0d got %0d",
						$time, want.fault, result.fault);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		instr_t  x;
		result_t pred;
		errors = 0;
		cycles = 0;
		hold_cnt = 0;
		no_idle = 1'b0;
		burst = 0;
		pc = '0;
		depth = 0;
		cmp_flag = FLAG_EQ;
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (opstack[i])
			opstack[i] = '0;

		// Faults on an empty machine, division corners, compare and flow
		dir_rows.push_back(mk_row(OP_NOP, 32'd0, 10'd0, 1, 10'd1, 0, 32'd0, FLT_NONE));
		dir_rows.push_back(mk_row(OP_POPR, 32'd0, 10'd1, 1, 10'd2, 0, 32'd0, FLT_UNDERFLOW));
		dir_rows.push_back(mk_row(OP_PUSHR, 32'd4, 10'd2, 1, 10'd3, 0, 32'd0, FLT_BADREG));
		dir_rows.push_back(mk_row(OP_POPR, 32'hFFFF_FFFF, 10'd3, 1, 10'd4, 0, 32'd0,
			FLT_BADREG));
		dir_rows.push_back(mk_row(OP_ADD, 32'd0, 10'd4, 1, 10'd5, 0, 32'd0, FLT_UNDERFLOW));
		dir_rows.push_back(mk_row(OP_RET, 32'd0, 10'd1023, 1, 10'd0, 0, 32'd0,
			FLT_UNDERFLOW));
		dir_rows.push_back(mk_row(OP_PUSHI, 32'h8000_0000, 10'd5, 1, 10'd6, 0, 32'd0,
			FLT_NONE));
		dir_rows.push_back(mk_row(OP_PUSHI, 32'hFFFF_FFFF, 10'd6, 0, 0, 0, 0, 0));
		// most negative over minus one
		dir_rows.push_back(mk_row(OP_DIV, 32'd0, 10'd7, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_PUSHI, 32'd0, 10'd8, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_MOD, 32'd0, 10'd9, 1, 10'd10, 0, 32'd0, FLT_DIVZERO));
		dir_rows.push_back(mk_row(OP_POPR, 32'd1, 10'd10, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_POPR, 32'd0, 10'd11, 1, 10'd12, 0, 32'h8000_0000,
			FLT_NONE));
		dir_rows.push_back(mk_row(OP_PUSHI, 32'h7FFF_FFFF, 10'd12, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_PUSHR, 32'd0, 10'd13, 0, 0, 0, 0, 0));
		// max against min must not overflow
		dir_rows.push_back(mk_row(OP_CMP, 32'd0, 10'd14, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_BGT, 32'h7FFF_FFFF, 10'd15, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_BLE, 32'd5, 10'd1023, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_CALL, 32'h8000_0064, 10'd1023, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_RET, 32'd0, 10'd100, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_PUSHI, 32'd0, 10'd0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_NOT, 32'd0, 10'd1, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_JMP, 32'h8000_0000, 10'd2, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_END, 32'hFFFF_FFFF, 10'd1023, 1, 10'd1023, 1,
			32'h8000_0000, FLT_NONE));
		// unused opcode behaves as nop
		dir_rows.push_back(mk_row(5'd31, 32'hFFFF_FFFF, 10'd1023, 0, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			pred = exec_step(dir_rows[i].ins);
			pc = pred.next_index;
			send_instr(dir_rows[i].ins, dir_rows[i].typed ? dir_rows[i].want : pred);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// stretches without any idling on either side
			no_idle = (i >= 300 && i < 450) || (i >= 900 && i < 1000);
			if (i % 200 == 100)
				burst = 1;
			x = gen_instr();
			pred = exec_step(x);
			pc = pred.next_index;
			send_instr(x, pred);
		end
		@(negedge clk);
		instr_valid <= 1'b0;
		no_idle = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
